FILE: rtl/clsm_pkg.sv
// Shared types, codes and the opcode classification table for the command
// latency statistics monitor. No dependencies; every other file but clsm_ram uses it.
package clsm_pkg;

  // Default number of command classes
  localparam int COMMAND_CLASSES_DEF = 88;

  // Event codes carried in the opcode field
  localparam logic [2:0] OP_CMD_START     = 3'd0;
  localparam logic [2:0] OP_CMD_FINISH    = 3'd1;
  localparam logic [2:0] OP_DATA_START    = 3'd2;
  localparam logic [2:0] OP_DATA_FINISH   = 3'd3;
  localparam logic [2:0] OP_STATUS_START  = 3'd4;
  localparam logic [2:0] OP_STATUS_FINISH = 3'd5;
  localparam logic [2:0] OP_READ_ENTRY    = 3'd6;

  // Transfer result codes
  localparam logic [2:0] RES_GOOD  = 3'd0;
  localparam logic [2:0] RES_ERROR = 3'd4;

  // Input transaction
  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  scsi_opcode;
    logic [62:0] timestamp_ns;
    logic        is_read;
    logic [31:0] transfer_length;
    logic [2:0]  transfer_result;
    logic [6:0]  entry_select;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic        touched;
    logic [6:0]  entry_index;
    logic [63:0] event_count;
    logic [63:0] error_count;
    logic [62:0] min_latency;
    logic [62:0] max_latency;
    logic [62:0] total_latency;
    logic [63:0] byte_total;
    logic [62:0] last_start;
  } out_item_t;

  // One statistics entry as held in the memory
  typedef struct packed {
    logic [63:0] count;
    logic [63:0] errors;
    logic [62:0] start_time;
    logic [62:0] min_lat;
    logic [62:0] max_lat;
    logic [62:0] total;
    logic [63:0] bytes;
  } entry_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC
  } state_t;

  // Kind of update an event makes
  typedef enum logic [2:0] {
    EV_NONE,
    EV_START,
    EV_CFIN,
    EV_DFIN,
    EV_SHOW
  } ev_kind_t;

  // Command class plus one for an opcode byte; zero means unclassified
  function automatic logic [7:0] class_plus1(input logic [7:0] b);
    logic [7:0] f;
    f = 8'd0;
    case (b)
      8'h00: f = 8'd1;  8'h01: f = 8'd2;  8'h03: f = 8'd3;  8'h04: f = 8'd4;
      8'h05: f = 8'd5;  8'h07: f = 8'd6;  8'h08: f = 8'd7;  8'h0a: f = 8'd8;
      8'h0b: f = 8'd9;  8'h0f: f = 8'd10; 8'h10: f = 8'd11; 8'h11: f = 8'd12;
      8'h12: f = 8'd13; 8'h14: f = 8'd14; 8'h15: f = 8'd15; 8'h16: f = 8'd16;
      8'h17: f = 8'd17; 8'h18: f = 8'd18; 8'h19: f = 8'd19; 8'h1a: f = 8'd20;
      8'h1b: f = 8'd21; 8'h1c: f = 8'd22; 8'h1d: f = 8'd23; 8'h1e: f = 8'd24;
      8'h24: f = 8'd25; 8'h25: f = 8'd26; 8'h28: f = 8'd27; 8'h2a: f = 8'd28;
      8'h2b: f = 8'd29; 8'h2e: f = 8'd30; 8'h2f: f = 8'd31; 8'h30: f = 8'd32;
      8'h31: f = 8'd33; 8'h32: f = 8'd34; 8'h33: f = 8'd35; 8'h34: f = 8'd36;
      8'h35: f = 8'd37; 8'h36: f = 8'd38; 8'h37: f = 8'd39; 8'h38: f = 8'd40;
      8'h39: f = 8'd41; 8'h3a: f = 8'd42; 8'h3b: f = 8'd43; 8'h3c: f = 8'd44;
      8'h3d: f = 8'd45; 8'h3e: f = 8'd46; 8'h3f: f = 8'd47; 8'h40: f = 8'd48;
      8'h41: f = 8'd49; 8'h42: f = 8'd50; 8'h43: f = 8'd51; 8'h44: f = 8'd52;
      8'h45: f = 8'd53; 8'h47: f = 8'd54; 8'h4a: f = 8'd55; 8'h4b: f = 8'd56;
      8'h4c: f = 8'd57; 8'h4d: f = 8'd58; 8'h4e: f = 8'd59; 8'h51: f = 8'd60;
      8'h52: f = 8'd61; 8'h53: f = 8'd62; 8'h54: f = 8'd63; 8'h55: f = 8'd64;
      8'h58: f = 8'd65; 8'h59: f = 8'd66; 8'h5a: f = 8'd67; 8'h5b: f = 8'd68;
      8'h5c: f = 8'd69; 8'h5d: f = 8'd70; 8'ha1: f = 8'd71; 8'ha0: f = 8'd72;
      8'ha5: f = 8'd73; 8'ha8: f = 8'd74; 8'haa: f = 8'd75; 8'hae: f = 8'd76;
      8'hb0: f = 8'd77; 8'hb1: f = 8'd78; 8'hb2: f = 8'd79; 8'hb6: f = 8'd80;
      8'hb8: f = 8'd81; 8'hb9: f = 8'd82; 8'hba: f = 8'd83; 8'hbb: f = 8'd84;
      8'hbd: f = 8'd85; 8'hbe: f = 8'd86; 8'he1: f = 8'd87; 8'hea: f = 8'd88;
      default: f = 8'd0;
    endcase
    return f;
  endfunction

endpackage

FILE: rtl/clsm_if.sv
// Valid/ready channel interfaces for the event input and the result output.
// Depends on clsm_pkg for the payload types.
interface clsm_in_if;
  logic                valid;
  logic                ready;
  clsm_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface clsm_out_if;
  logic                valid;
  logic                ready;
  clsm_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/command_latency_stats_monitor.sv
// Top level of the command latency statistics monitor.
// Depends on clsm_pkg, clsm_if (channel interfaces) and clsm_ram.

// The result register is loaded in the update step: the statistics memory is
// read at the accepting edge, the read step (ST_READ) registers the latency
// (timestamp minus stored start) and the update step (ST_CALC) applies the
// update, writes the entry back and loads the result register. Events are
// processed one at a time: no new event is accepted until the update step is
// done, and that step waits while a result is held by the downstream side. All
// entries (COMMAND_CLASSES command classes, then status, read and write) live in
// one memory; a valid bit per entry, cleared at reset, makes an unwritten entry
// read as zero, so no clearing pass is needed and events are accepted straight
// after reset. Unclassified opcode bytes, opcode 7 and out-of-range entry
// selections give one result with touched low and all other fields zero.
module command_latency_stats_monitor #(
  parameter int COMMAND_CLASSES = clsm_pkg::COMMAND_CLASSES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  clsm_in_if.sink     in_ch,
  clsm_out_if.source  out_ch
);

  localparam int NUM_ENT = COMMAND_CLASSES + 3;
  localparam int IDX_W   = $clog2(NUM_ENT);
  localparam int ENT_W   = $bits(clsm_pkg::entry_t);
  localparam logic [IDX_W-1:0] IDX_ST = IDX_W'(COMMAND_CLASSES);
  localparam logic [IDX_W-1:0] IDX_RD = IDX_W'(COMMAND_CLASSES + 1);
  localparam logic [IDX_W-1:0] IDX_WR = IDX_W'(COMMAND_CLASSES + 2);

  clsm_pkg::state_t    state_r, state_nxt;
  clsm_pkg::ev_kind_t  kind_r, kind_c;
  logic [IDX_W-1:0]    idx_r, idx_c;
  logic [7:0]          cls_c;
  logic [62:0]         ts_r;
  logic [31:0]         len_r;
  logic [2:0]          res_r;
  logic                hit_vld_r;
  logic [NUM_ENT-1:0]  vld_r;
  clsm_pkg::entry_t    cur_r, rd_ent, upd;
  logic [62:0]         lat_r;
  logic [63:0]         sum;
  logic                in_acc, advance, ram_we;
  logic [ENT_W-1:0]    ram_rdata;
  logic                out_vld_r;
  clsm_pkg::out_item_t out_data_r, out_nxt;

  assign in_acc = in_ch.valid && in_ch.ready;

  // event decode: pick the entry and kind of update
  always_comb begin
    kind_c = clsm_pkg::EV_NONE;
    idx_c  = '0;
    cls_c  = clsm_pkg::class_plus1(in_ch.data.scsi_opcode);
    case (in_ch.data.opcode)
      clsm_pkg::OP_CMD_START, clsm_pkg::OP_CMD_FINISH: begin
        if (cls_c != 8'd0 && int'(cls_c) <= COMMAND_CLASSES) begin
          idx_c  = IDX_W'(cls_c - 8'd1);
          kind_c = (in_ch.data.opcode == clsm_pkg::OP_CMD_START) ?
                   clsm_pkg::EV_START : clsm_pkg::EV_CFIN;
        end
      end
      clsm_pkg::OP_DATA_START: begin
        idx_c  = in_ch.data.is_read ? IDX_RD : IDX_WR;
        kind_c = clsm_pkg::EV_START;
      end
      clsm_pkg::OP_DATA_FINISH: begin
        idx_c  = in_ch.data.is_read ? IDX_RD : IDX_WR;
        kind_c = clsm_pkg::EV_DFIN;
      end
      clsm_pkg::OP_STATUS_START: begin
        idx_c  = IDX_ST;
        kind_c = clsm_pkg::EV_START;
      end
      clsm_pkg::OP_STATUS_FINISH: begin
        idx_c  = IDX_ST;
        kind_c = clsm_pkg::EV_CFIN;
      end
      clsm_pkg::OP_READ_ENTRY: begin
        if (int'(in_ch.data.entry_select) <= COMMAND_CLASSES + 2) begin
          idx_c  = IDX_W'(in_ch.data.entry_select);
          kind_c = clsm_pkg::EV_SHOW;
        end
      end
      default: ;
    endcase
  end

  // statistics memory
  clsm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_ENT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (upd),
    .re    (in_acc),
    .raddr (idx_c),
    .rdata (ram_rdata)
  );

  // an entry never written reads as zero
  assign rd_ent = hit_vld_r ? clsm_pkg::entry_t'(ram_rdata) : '0;

  // sequencer
  assign advance = (state_r == clsm_pkg::ST_CALC) && (!out_vld_r || out_ch.ready);
  assign ram_we  = advance && (kind_r == clsm_pkg::EV_START ||
                               kind_r == clsm_pkg::EV_CFIN ||
                               kind_r == clsm_pkg::EV_DFIN);
  assign in_ch.ready = (state_r == clsm_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      clsm_pkg::ST_IDLE: if (in_acc) state_nxt = clsm_pkg::ST_READ;
      clsm_pkg::ST_READ: state_nxt = clsm_pkg::ST_CALC;
      clsm_pkg::ST_CALC: if (advance) state_nxt = clsm_pkg::ST_IDLE;
      default:           state_nxt = clsm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= clsm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // capture the event at acceptance
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r    <= kind_c;
      idx_r     <= idx_c;
      ts_r      <= in_ch.data.timestamp_ns;
      len_r     <= in_ch.data.transfer_length;
      res_r     <= in_ch.data.transfer_result;
      hit_vld_r <= vld_r[idx_c];
    end
  end

  // latency against the stored start time
  always_ff @(posedge clk) begin
    if (state_r == clsm_pkg::ST_READ) begin
      cur_r <= rd_ent;
      lat_r <= ts_r - rd_ent.start_time;
    end
  end

  // entry update
  always_comb begin
    upd = cur_r;
    sum = {1'b0, cur_r.total} + {1'b0, lat_r};
    case (kind_r)
      clsm_pkg::EV_START: begin
        upd.count      = cur_r.count + 64'd1;
        upd.start_time = ts_r;
      end
      clsm_pkg::EV_CFIN: begin
        if (res_r != clsm_pkg::RES_GOOD) begin
          upd.errors = cur_r.errors + 64'd1;
        end else if (sum[63]) begin
          upd = '0;
        end else begin
          if (cur_r.count == 64'd1) begin
            upd.min_lat = lat_r;
            upd.max_lat = lat_r;
          end else if (lat_r < cur_r.min_lat) begin
            upd.min_lat = lat_r;
          end else if (lat_r > cur_r.max_lat) begin
            upd.max_lat = lat_r;
          end
          upd.total = sum[62:0];
        end
      end
      clsm_pkg::EV_DFIN: begin
        if (res_r == clsm_pkg::RES_ERROR) begin
          upd.errors = cur_r.errors + 64'd1;
        end else if (sum[63]) begin
          upd = '0;
        end else begin
          upd.bytes = cur_r.bytes + {32'd0, len_r};
          upd.total = sum[62:0];
        end
      end
      default: ;
    endcase
  end

  // result formatting
  always_comb begin
    out_nxt = '0;
    if (kind_r != clsm_pkg::EV_NONE) begin
      out_nxt.touched       = 1'b1;
      out_nxt.entry_index   = 7'(idx_r);
      out_nxt.event_count   = upd.count;
      out_nxt.error_count   = upd.errors;
      out_nxt.min_latency   = upd.min_lat;
      out_nxt.max_latency   = upd.max_lat;
      out_nxt.total_latency = upd.total;
      out_nxt.byte_total    = upd.bytes;
      out_nxt.last_start    = upd.start_time;
    end
  end

  // entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ram_we) begin
      vld_r[idx_r] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_data_r;

  // checks
  a_acc_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == clsm_pkg::ST_READ ##1 state_r == clsm_pkg::ST_CALC)
    else $error("accepted transaction did not enter the read and update steps");

  a_no_wr_on_acc: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !in_acc)
    else $error("memory write overlaps a new transaction");

  a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_data_r.touched |->
      out_data_r.entry_index == 7'd0 && out_data_r.event_count == 64'd0 &&
      out_data_r.error_count == 64'd0 && out_data_r.total_latency == 63'd0 &&
      out_data_r.byte_total == 64'd0 && out_data_r.last_start == 63'd0)
    else $error("ignored event produced non-zero fields");

  a_data_no_minmax: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (idx_r == IDX_RD || idx_r == IDX_WR) && kind_r != clsm_pkg::EV_NONE |->
      upd.min_lat == 63'd0 && upd.max_lat == 63'd0)
    else $error("transfer entry carries latency extremes");

  a_out_after_calc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r) == clsm_pkg::ST_CALC)
    else $error("result appeared outside the update step");

endmodule

FILE: rtl/clsm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module clsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: tb/tb_command_latency_stats_monitor.sv
// Self-checking testbench for command_latency_stats_monitor: random and directed
// event streams with a behavioural statistics predictor and an in-order result check.
// Depends on clsm_pkg, the clsm_if channel interfaces and the RTL top level.
module tb_command_latency_stats_monitor;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes the package leaves unnamed
  localparam logic [2:0] OP_UNUSED   = 3'd7;
  localparam logic [2:0] RES_SHORT   = 3'd1;
  localparam logic [2:0] RES_STALLED = 3'd2;
  localparam logic [2:0] RES_UNDEF6  = 3'd6;
  localparam logic [2:0] RES_UNDEF7  = 3'd7;

  // Entry numbering: command classes, then status, read and write
  localparam int NUM_CLASSES = clsm_pkg::COMMAND_CLASSES_DEF;
  localparam int ENT_STATUS  = NUM_CLASSES;
  localparam int ENT_READ    = NUM_CLASSES + 1;
  localparam int ENT_WRITE   = NUM_CLASSES + 2;

  localparam logic [62:0] TS_MAX    = {63{1'b1}};
  localparam int          RAND_ITEMS  = 2000;
  localparam int          STALL_LIMIT = 1000;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          BURST_FROM = 700;
  localparam int          BURST_TO   = 1000;

  // Opcode bytes in class order
  localparam logic [0:87][7:0] CLASS_BYTES = {
    8'h00, 8'h01, 8'h03, 8'h04, 8'h05, 8'h07, 8'h08, 8'h0a, 8'h0b, 8'h0f,
    8'h10, 8'h11, 8'h12, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
    8'h1b, 8'h1c, 8'h1d, 8'h1e, 8'h24, 8'h25, 8'h28, 8'h2a, 8'h2b, 8'h2e,
    8'h2f, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e, 8'h3f, 8'h40, 8'h41, 8'h42,
    8'h43, 8'h44, 8'h45, 8'h47, 8'h4a, 8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h51,
    8'h52, 8'h53, 8'h54, 8'h55, 8'h58, 8'h59, 8'h5a, 8'h5b, 8'h5c, 8'h5d,
    8'ha1, 8'ha0, 8'ha5, 8'ha8, 8'haa, 8'hae, 8'hb0, 8'hb1, 8'hb2, 8'hb6,
    8'hb8, 8'hb9, 8'hba, 8'hbb, 8'hbd, 8'hbe, 8'he1, 8'hea
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  clsm_in_if  in_ch ();
  clsm_out_if out_ch ();

  command_latency_stats_monitor u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state, one record per entry
  clsm_pkg::entry_t    stats [0:ENT_WRITE];
  clsm_pkg::in_item_t  pending_events [$];
  clsm_pkg::out_item_t expected_views [$];
  int        n_events;
  int        n_sent;
  int        n_views;
  int        mismatches;
  int        stall_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Command class of an opcode byte, -1 when it has none
  function automatic int class_index(logic [7:0] b);
    for (int k = 0; k < NUM_CLASSES; k++) begin
      if (CLASS_BYTES[k] == b) return k;
    end
    return -1;
  endfunction

  function automatic logic [62:0] rand63();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[62:0];
  endfunction

  // Fully random transaction; callers override the fields that matter
  function automatic clsm_pkg::in_item_t random_event();
    clsm_pkg::in_item_t ev;
    ev.opcode          = 3'($urandom);
    ev.scsi_opcode     = 8'($urandom);
    ev.timestamp_ns    = rand63();
    ev.is_read         = 1'($urandom);
    ev.transfer_length = $urandom;
    ev.transfer_result = 3'($urandom);
    ev.entry_select    = 7'($urandom);
    return ev;
  endfunction

  function automatic clsm_pkg::in_item_t make_event(logic [2:0] op, logic [7:0] b,
                                                    logic [62:0] ts, logic rd,
                                                    logic [31:0] len, logic [2:0] res,
                                                    logic [6:0] sel);
    clsm_pkg::in_item_t ev;
    ev.opcode          = op;
    ev.scsi_opcode     = b;
    ev.timestamp_ns    = ts;
    ev.is_read         = rd;
    ev.transfer_length = len;
    ev.transfer_result = res;
    ev.entry_select    = sel;
    return ev;
  endfunction

  // Take a gap with a chance of 28 in a hundred, never inside the burst window
  function automatic bit take_gap(int n);
    if (n >= BURST_FROM && n < BURST_TO) return 1'b0;
    return $urandom_range(99) < 28;
  endfunction

  // Apply one accepted event to the statistics and return the entry view
  task automatic update_stats(input clsm_pkg::in_item_t ev,
                              output clsm_pkg::out_item_t view);
    int          idx;
    logic [62:0] lat;
    logic [63:0] sum;
    bit          good;
    view = '0;
    good = 1'b0;
    case (ev.opcode)
      clsm_pkg::OP_CMD_START, clsm_pkg::OP_CMD_FINISH:
        idx = class_index(ev.scsi_opcode);
      clsm_pkg::OP_DATA_START, clsm_pkg::OP_DATA_FINISH:
        idx = ev.is_read ? ENT_READ : ENT_WRITE;
      clsm_pkg::OP_STATUS_START, clsm_pkg::OP_STATUS_FINISH:
        idx = ENT_STATUS;
      clsm_pkg::OP_READ_ENTRY:
        idx = (ev.entry_select <= ENT_WRITE) ? int'(ev.entry_select) : -1;
      default:
        idx = -1;
    endcase
    if (idx < 0) return;

    // Latency wraps modulo the timestamp range, so an early finish gives a huge value
    lat = ev.timestamp_ns - stats[idx].start_time;
    case (ev.opcode)
      clsm_pkg::OP_CMD_START, clsm_pkg::OP_DATA_START, clsm_pkg::OP_STATUS_START: begin
        stats[idx].count      = stats[idx].count + 64'd1;
        stats[idx].start_time = ev.timestamp_ns;
      end
      clsm_pkg::OP_CMD_FINISH, clsm_pkg::OP_STATUS_FINISH: begin
        if (ev.transfer_result != clsm_pkg::RES_GOOD) begin
          stats[idx].errors = stats[idx].errors + 64'd1;
        end else begin
          good = 1'b1;
          if (stats[idx].count == 64'd1) begin
            stats[idx].min_lat = lat;
            stats[idx].max_lat = lat;
          end else if (lat < stats[idx].min_lat) begin
            stats[idx].min_lat = lat;
          end else if (lat > stats[idx].max_lat) begin
            stats[idx].max_lat = lat;
          end
        end
      end
      clsm_pkg::OP_DATA_FINISH: begin
        // Only the error code fails a transfer; undefined codes count as moved
        if (ev.transfer_result == clsm_pkg::RES_ERROR) begin
          stats[idx].errors = stats[idx].errors + 64'd1;
        end else begin
          good = 1'b1;
          stats[idx].bytes = stats[idx].bytes + 64'(ev.transfer_length);
        end
      end
      default: ;
    endcase

    // Total past 63 bits wipes the whole entry
    if (good) begin
      sum = {1'b0, stats[idx].total} + {1'b0, lat};
      if (sum[63]) stats[idx] = '0;
      else stats[idx].total = sum[62:0];
    end

    view.touched       = 1'b1;
    view.entry_index   = 7'(idx);
    view.event_count   = stats[idx].count;
    view.error_count   = stats[idx].errors;
    view.min_latency   = stats[idx].min_lat;
    view.max_latency   = stats[idx].max_lat;
    view.total_latency = stats[idx].total;
    view.byte_total    = stats[idx].bytes;
    view.last_start    = stats[idx].start_time;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
    end
  endtask

  task automatic check_view(input clsm_pkg::out_item_t got);
    clsm_pkg::out_item_t want;
    if (expected_views.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result for entry %0d", $realtime, got.entry_index);
      return;
    end
    want = expected_views.pop_front();
    check_field("touched",       64'(want.touched),       64'(got.touched));
    check_field("entry_index",   64'(want.entry_index),   64'(got.entry_index));
    check_field("event_count",   want.event_count,        got.event_count);
    check_field("error_count",   want.error_count,        got.error_count);
    check_field("min_latency",   64'(want.min_latency),   64'(got.min_latency));
    check_field("max_latency",   64'(want.max_latency),   64'(got.max_latency));
    check_field("total_latency", 64'(want.total_latency), 64'(got.total_latency));
    check_field("byte_total",    want.byte_total,         got.byte_total);
    check_field("last_start",    64'(want.last_start),    64'(got.last_start));
  endtask

  // Driver: predict on acceptance, then present the next pending event
  always @(posedge clk) begin
    clsm_pkg::out_item_t view;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        update_stats(in_ch.data, view);
        expected_views.push_back(view);
        n_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_events.size() > 0 && !take_gap(n_sent)) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= pending_events.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result, random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_view(out_ch.data);
        n_views++;
      end
      out_ch.ready <= !take_gap(n_views);
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [62:0]        t_now;
    logic [62:0]        delta;
    logic [7:0]         b;
    clsm_pkg::in_item_t ev;
    int                 pick;
    int                 n_rand;

    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    n_sent       = 0;
    n_views      = 0;
    mismatches   = 0;
    stall_cycles = 0;
    for (int k = 0; k <= ENT_WRITE; k++) stats[k] = '0;

    // Directed: first good finish sets min and max, then a new min, then a new max
    pending_events.push_back(make_event(clsm_pkg::OP_CMD_START, 8'h00, 63'd100, 1'b0, 0,
                                        clsm_pkg::RES_GOOD, 0));
    pending_events.push_back(make_event(clsm_pkg::OP_CMD_FINISH, 8'h00, 63'd150, 1'b0, 0,
                                        clsm_pkg::RES_GOOD, 0));
    pending_events.push_back(make_event(clsm_pkg::OP_CMD_START, 8'h00, 63'd200, 1'b0, 0,
                                        clsm_pkg::RES_GOOD, 0));
    pending_events.push_back(make_event(clsm_pkg::OP_CMD_FINISH, 8'h00, 63'd210, 1'b0, 0,
                                        clsm_pkg::RES_GOOD, 0));
    pending_events.push_back(make_event(clsm_pkg::OP_CMD_START, 8'h00, 63'd300, 1'b0, 0,
                                        clsm_pkg::RES_GOOD, 0));
    pending_events.push_back(make_event(clsm_pkg::OP_CMD_FINISH, 8'h00, 63'd400, 1'b0, 0,
                                        clsm_pkg::RES_GOOD, 0));
    // Failed finishes, including an undefined result code
    pending_events.push_back(make_event(clsm_pkg::OP_CMD_FINISH, 8'h00, 63'd450, 1'b0, 0,
                                        clsm_pkg::RES_ERROR, 0));
    pending_events.push_back(make_event(clsm_pkg::OP_CMD_FINISH, 8'h00, 63'd460, 1'b0, 0,
                                        RES_UNDEF7, 0));
    // Unclassified opcode byte and the last class
    pending_events.push_back(make_event(clsm_pkg::OP_CMD_START, 8'hff, TS_MAX, 1'b1, 0,
                                        clsm_pkg::RES_GOOD, 0));
    pending_events.push_back(make_event(clsm_pkg::OP_CMD_START, 8'hea, TS_MAX, 1'b0, 0,
                                        clsm_pkg::RES_GOOD, 0));
    // Finish before its start, then a total overflow that clears the entry
    pending_events.push_back(make_event(clsm_pkg::OP_CMD_START, 8'he1, 63'd1000, 1'b0, 0,
                                        clsm_pkg::RES_GOOD, 0));
    pending_events.push_back(make_event(clsm_pkg::OP_CMD_FINISH, 8'he1, 63'd10, 1'b0, 0,
                                        clsm_pkg::RES_GOOD, 0));
    pending_events.push_back(make_event(clsm_pkg::OP_CMD_START, 8'he1, 63'd0, 1'b0, 0,
                                        clsm_pkg::RES_GOOD, 0));
    pending_events.push_back(make_event(clsm_pkg::OP_CMD_FINISH, 8'he1, TS_MAX, 1'b0, 0,
                                        clsm_pkg::RES_GOOD, 0));
    // Finish on an entry never started
    pending_events.push_back(make_event(clsm_pkg::OP_CMD_FINISH, 8'h59, 63'd5, 1'b0, 0,
                                        clsm_pkg::RES_GOOD, 0));
    // Status phase
    pending_events.push_back(make_event(clsm_pkg::OP_STATUS_START, 8'h00, 63'd500, 1'b0, 0,
                                        clsm_pkg::RES_GOOD, 0));
    pending_events.push_back(make_event(clsm_pkg::OP_STATUS_FINISH, 8'h00, 63'd530, 1'b0, 0,
                                        clsm_pkg::RES_GOOD, 0));
    pending_events.push_back(make_event(clsm_pkg::OP_STATUS_FINISH, 8'h00, 63'd540, 1'b0, 0,
                                        RES_SHORT, 0));
    // Data phases, both directions, error and undefined codes
    pending_events.push_back(make_event(clsm_pkg::OP_DATA_START, 8'h00, 63'd1000, 1'b1, 0,
                                        clsm_pkg::RES_GOOD, 0));
    pending_events.push_back(make_event(clsm_pkg::OP_DATA_FINISH, 8'h00, 63'd1500, 1'b1, '1,
                                        clsm_pkg::RES_GOOD, 0));
    pending_events.push_back(make_event(clsm_pkg::OP_DATA_FINISH, 8'h00, 63'd1600, 1'b1,
                                        32'd9, clsm_pkg::RES_ERROR, 0));
    pending_events.push_back(make_event(clsm_pkg::OP_DATA_START, 8'h00, 63'd7, 1'b0, 0,
                                        clsm_pkg::RES_GOOD, 0));
    pending_events.push_back(make_event(clsm_pkg::OP_DATA_FINISH, 8'h00, 63'd70, 1'b0,
                                        32'd12345, RES_UNDEF6, 0));
    // Entry reads at the edges of the numbering, out of range, and the unused opcode
    pending_events.push_back(make_event(clsm_pkg::OP_READ_ENTRY, 8'h00, 0, 1'b0, 0,
                                        clsm_pkg::RES_GOOD, 7'd0));
    pending_events.push_back(make_event(clsm_pkg::OP_READ_ENTRY, 8'h00, 0, 1'b0, 0,
                                        clsm_pkg::RES_GOOD, 7'(ENT_WRITE)));
    pending_events.push_back(make_event(clsm_pkg::OP_READ_ENTRY, 8'h00, 0, 1'b0, 0,
                                        clsm_pkg::RES_GOOD, '1));
    pending_events.push_back(make_event(OP_UNUSED, 8'h00, 63'd1, 1'b1, 0, RES_STALLED, 0));

    // Random: mostly start/finish pairs on a rising clock, some reads and noise
    t_now  = 63'd2000;
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        if ($urandom_range(49) == 0) t_now = rand63();
        t_now = t_now + 63'($urandom_range(1, 1000));
        delta = 63'($urandom_range(0, 5000));
        ev = random_event();
        ev.timestamp_ns = t_now;
        case ($urandom_range(2))
          0: begin
            b = ($urandom_range(1)) ? CLASS_BYTES[$urandom_range(3)] :
                                      CLASS_BYTES[$urandom_range(NUM_CLASSES - 1)];
            ev.scsi_opcode = b;
            ev.opcode = clsm_pkg::OP_CMD_START;
            pending_events.push_back(ev);
            ev.opcode = clsm_pkg::OP_CMD_FINISH;
          end
          1: begin
            ev.opcode = clsm_pkg::OP_STATUS_START;
            pending_events.push_back(ev);
            ev.opcode = clsm_pkg::OP_STATUS_FINISH;
          end
          default: begin
            ev.opcode = clsm_pkg::OP_DATA_START;
            pending_events.push_back(ev);
            ev.opcode = clsm_pkg::OP_DATA_FINISH;
          end
        endcase
        ev.timestamp_ns    = t_now + delta;
        ev.transfer_result = ($urandom_range(4) != 0) ? clsm_pkg::RES_GOOD : 3'($urandom);
        pending_events.push_back(ev);
        t_now  = t_now + delta;
        n_rand += 2;
      end else if (pick < 75) begin
        ev = random_event();
        ev.opcode = clsm_pkg::OP_READ_ENTRY;
        if ($urandom_range(4) != 0) ev.entry_select = 7'($urandom_range(ENT_WRITE));
        pending_events.push_back(ev);
        n_rand++;
      end else begin
        pending_events.push_back(random_event());
        n_rand++;
      end
    end
    n_events = pending_events.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (n_sent < n_events || expected_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/clsm_pkg.sv
rtl/clsm_if.sv
rtl/clsm_ram.sv
rtl/command_latency_stats_monitor.sv
tb/tb_command_latency_stats_monitor.sv
